// ----- rtl/zblr_pkg.sv -----
// Shared types and constants for the z-buffered line raster unit.
package zblr_pkg;

  localparam int IMG_W_DEF      = 64;
  localparam int IMG_H_DEF      = 64;
  localparam int DEPTH_BITS_DEF = 32;

  // divider operand width: covers 2^33 + z and 2*(r1 - r0)
  localparam int DIV_W   = 37;
  localparam int DIV_CW  = 6;

  typedef struct packed {
    logic [5:0]         start_x;
    logic [5:0]         start_y;
    logic signed [31:0] start_depth;
    logic [5:0]         end_x;
    logic [5:0]         end_y;
    logic signed [31:0] end_depth;
    logic [23:0]        line_color;
  } line_t;

  typedef struct packed {
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [23:0] pixel_color;
    logic        visible;
    logic        last;
  } pixel_t;

  typedef struct packed {
    logic                    start;
    logic signed [DIV_W-1:0] num;
    logic [DIV_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [DIV_W-1:0] quo;
    logic [DIV_W-1:0]        rem;
  } div_rsp_t;

endpackage

// ----- rtl/zblr_div.sv -----
// Bit-serial floor divider: signed numerator over positive denominator.
module zblr_div (
  input  logic               clk,
  input  logic               rst,
  input  zblr_pkg::div_req_t req,
  output zblr_pkg::div_rsp_t rsp
);

  localparam int W = zblr_pkg::DIV_W;

  logic                       busy;
  logic                       done;
  logic [zblr_pkg::DIV_CW-1:0] cnt;
  logic [W-1:0]               mag;
  logic [W-1:0]               rem;
  logic [W-1:0]               den;
  logic                       neg;
  logic [W-1:0]               rem_sh;
  logic                       ge;

  assign rem_sh = {rem[W-2:0], mag[W-1]};
  assign ge     = rem_sh >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= zblr_pkg::DIV_CW'(W - 1);
        rem  <= '0;
        mag  <= req.num[W-1] ? W'(-req.num) : W'(req.num);
        neg  <= req.num[W-1];
        den  <= req.den;
      end else if (busy) begin
        rem <= ge ? rem_sh - den : rem_sh;
        mag <= {mag[W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // floor correction for a negative numerator
  always_comb begin
    rsp.done = done;
    if (!neg) begin
      rsp.quo = $signed(mag);
      rsp.rem = rem;
    end else if (rem == '0) begin
      rsp.quo = -$signed(mag);
      rsp.rem = '0;
    end else begin
      rsp.quo = $signed(~mag);
      rsp.rem = den - rem;
    end
  end

endmodule

// ----- rtl/zblr_zmem.sv -----
// Depth store with a clearing pass after reset; registered read.
module zblr_zmem #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  output logic          busy
);

  localparam logic [DW-1:0] FAR = {1'b0, {(DW-1){1'b1}}};

  logic [DW-1:0] mem [DEPTH];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == AW'(DEPTH - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= FAR;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule

// ----- rtl/zbuffered_line_raster_unit.sv -----
// Top level: line setup sequencer, pixel stepper and depth test.
//
// After reset the depth store is swept to "far" one entry a cycle, and no
// line is taken until the sweep is done. An accepted line then takes two
// reciprocal divisions and one slope division (the last skipped for a
// single point) on one shared bit-serial divider, then for each pixel a
// store read step, then a test and write-back step.
// Output stall holds the pixel loop at the write-back step.
module zbuffered_line_raster_unit #(
  parameter int IMG_W      = zblr_pkg::IMG_W_DEF,
  parameter int IMG_H      = zblr_pkg::IMG_H_DEF,
  parameter int DEPTH_BITS = zblr_pkg::DEPTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  zblr_pkg::line_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output zblr_pkg::pixel_t out_data
);

  localparam int DW    = zblr_pkg::DIV_W;
  localparam int DEPTH = IMG_W * IMG_H;
  localparam int AW    = $clog2(DEPTH);
  localparam int XL    = (IMG_W - 1 > 63) ? 63 : IMG_W - 1;
  localparam int YL    = (IMG_H - 1 > 63) ? 63 : IMG_H - 1;
  localparam logic [5:0]    XLIM = 6'(XL);
  localparam logic [5:0]    YLIM = 6'(YL);
  localparam logic [AW-1:0] ROW  = AW'(IMG_W);
  localparam logic signed [48:0] VMAX = (49'sd1 <<< (DEPTH_BITS - 1)) - 49'sd1;
  localparam logic signed [48:0] VMIN = -VMAX - 49'sd1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DR0  = 3'd1;
  localparam logic [2:0] S_DR1  = 3'd2;
  localparam logic [2:0] S_DD   = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_WR   = 3'd5;

  // reciprocal round_half_up(2^32/z) as a floor division
  function automatic zblr_pkg::div_req_t recip_req(input logic signed [31:0] z);
    logic signed [DW-1:0] zz;
    logic signed [DW-1:0] n;
    logic signed [DW-1:0] d;
    zblr_pkg::div_req_t   r;
    zz = (z == 32'sd0) ? DW'(1) : DW'(z);
    n  = (DW'(1) <<< 33) + zz;
    d  = zz <<< 1;
    if (d < 0) begin
      n = -n;
      d = -d;
    end
    r.start = 1'b0;
    r.num   = n;
    r.den   = DW'(d);
    return r;
  endfunction

  logic [2:0]            state;
  logic                  dstart;
  zblr_pkg::div_req_t    div_req;
  zblr_pkg::div_rsp_t    div_rsp;

  logic signed [31:0]    za, zb;
  logic [23:0]           color;
  logic                  shallow, dir_neg;
  logic [5:0]            maj, cnt;
  logic [6:0]            twoa;
  logic signed [7:0]     mnr;
  logic [7:0]            mr;
  logic signed [1:0]     mqd;
  logic [6:0]            mrd;
  logic signed [DW-1:0]  r0, r1, q, qd;
  logic [7:0]            qr;
  logic [6:0]            qrd;

  logic                  mem_busy;
  logic [DEPTH_BITS-1:0] rd_data;
  logic                  wr_en;
  logic [AW-1:0]         addr;

  // accept-time setup
  logic [5:0]        cx0, cy0, cx1, cy1, sx, sy, ex, ey;
  logic              swap, shl;
  logic [6:0]        dx;
  logic signed [7:0] dy, dm, tw;
  logic [5:0]        ady, a;

  always_comb begin
    cx0  = (in_data.start_x > XLIM) ? XLIM : in_data.start_x;
    cy0  = (in_data.start_y > YLIM) ? YLIM : in_data.start_y;
    cx1  = (in_data.end_x   > XLIM) ? XLIM : in_data.end_x;
    cy1  = (in_data.end_y   > YLIM) ? YLIM : in_data.end_y;
    swap = (cx0 > cx1) || ((cx0 == cx1) && (cy0 > cy1));
    sx   = swap ? cx1 : cx0;
    sy   = swap ? cy1 : cy0;
    ex   = swap ? cx0 : cx1;
    ey   = swap ? cy0 : cy1;
    dx   = {1'b0, ex} - {1'b0, sx};
    dy   = $signed({2'b00, ey}) - $signed({2'b00, sy});
    ady  = dy[7] ? 6'(-dy) : 6'(dy);
    shl  = {1'b0, ady} <= dx;
    a    = shl ? dx[5:0] : ady;
    dm   = shl ? (dy <<< 1) : $signed({dx, 1'b0});
    tw   = $signed({1'b0, a, 1'b0});
  end

  // pixel step
  logic [5:0]        px, py;
  logic signed [48:0] qe;
  logic [DEPTH_BITS-1:0] val;
  logic              vis, out_free;
  logic [7:0]        mr_sum, qr_sum;
  logic              mc, qc;

  always_comb begin
    px  = shallow ? maj : mnr[5:0];
    py  = shallow ? mnr[5:0] : maj;
    addr = AW'(py) * ROW + AW'(px);
    qe  = 49'(q);
    if (qe > VMAX)      val = DEPTH_BITS'(VMAX);
    else if (qe < VMIN) val = DEPTH_BITS'(VMIN);
    else                val = DEPTH_BITS'(qe);
    vis      = $signed(val) <= $signed(rd_data);
    out_free = !out_valid || !out_stall;
    wr_en    = (state == S_WR) && out_free && vis;
    mr_sum   = mr + {1'b0, mrd};
    mc       = mr_sum >= {1'b0, twoa};
    qr_sum   = qr + {1'b0, qrd};
    qc       = qr_sum >= {1'b0, twoa};
  end

  always_comb begin
    case (state)
      S_DR0:   div_req = recip_req(za);
      S_DR1:   div_req = recip_req(zb);
      default: begin
        div_req.num = (r1 - r0) <<< 1;
        div_req.den = DW'(twoa);
        div_req.start = 1'b0;
      end
    endcase
    div_req.start = dstart;
  end

  assign in_stall = (state != S_IDLE) || mem_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      dstart    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      dstart <= (state == S_IDLE && in_valid && !in_stall) ||
                (state == S_DR0 && div_rsp.done) ||
                (state == S_DR1 && div_rsp.done && cnt != '0);
      if (state == S_WR && out_free) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) state <= S_DR0;
        end
        S_DR0: begin
          if (div_rsp.done) state <= S_DR1;
        end
        S_DR1: begin
          if (div_rsp.done) state <= (cnt == '0) ? S_RD : S_DD;
        end
        S_DD: begin
          if (div_rsp.done) state <= S_RD;
        end
        S_RD: state <= S_WR;
        S_WR: begin
          if (out_free) state <= (cnt == '0) ? S_IDLE : S_RD;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid && !in_stall) begin
      za      <= swap ? in_data.end_depth : in_data.start_depth;
      zb      <= swap ? in_data.start_depth : in_data.end_depth;
      color   <= in_data.line_color;
      shallow <= shl;
      dir_neg <= !shl && dy[7];
      maj     <= shl ? sx : sy;
      mnr     <= shl ? $signed({2'b00, sy}) : $signed({2'b00, sx});
      cnt     <= a;
      twoa    <= {a, 1'b0};
      mr      <= {2'b00, a};
      qd      <= '0;
      qrd     <= '0;
      if (dm == tw) begin
        mqd <= 2'sd1;
        mrd <= '0;
      end else if (!dm[7]) begin
        mqd <= 2'sd0;
        mrd <= dm[6:0];
      end else if (dm == -tw) begin
        mqd <= -2'sd1;
        mrd <= '0;
      end else begin
        mqd <= -2'sd1;
        mrd <= 7'(dm + tw);
      end
    end
    if (state == S_DR0 && div_rsp.done) begin
      r0 <= div_rsp.quo;
      q  <= div_rsp.quo;
      qr <= {1'b0, twoa[6:0]} >> 1;
    end
    if (state == S_DR1 && div_rsp.done) r1 <= div_rsp.quo;
    if (state == S_DD && div_rsp.done) begin
      qd  <= div_rsp.quo;
      qrd <= div_rsp.rem[6:0];
    end
    if (state == S_WR && out_free) begin
      out_data.pixel_x     <= px;
      out_data.pixel_y     <= py;
      out_data.pixel_color <= vis ? color : 24'd0;
      out_data.visible     <= vis;
      out_data.last        <= cnt == '0;
      maj <= dir_neg ? maj - 1'b1 : maj + 1'b1;
      mnr <= mnr + 8'(mqd) + (mc ? 8'sd1 : 8'sd0);
      mr  <= mc ? mr_sum - {1'b0, twoa} : mr_sum;
      q   <= q + qd + (qc ? DW'(1) : DW'(0));
      qr  <= qc ? qr_sum - {1'b0, twoa} : qr_sum;
      cnt <= cnt - 1'b1;
    end
  end

  zblr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  zblr_zmem #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (DEPTH_BITS)
  ) u_zmem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (state == S_RD),
    .rd_addr (addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (addr),
    .wr_data (val),
    .busy    (mem_busy)
  );

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == S_DR0 || state == S_DR1 || state == S_DD))
    else $error("divider result outside a division step");

  a_no_line_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !mem_busy)
    else $error("line in progress during store clear");

  a_accept_starts_div: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == S_DR0 && dstart))
    else $error("accepted line did not start setup");

  a_hidden_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.visible) |-> (out_data.pixel_color == 24'd0))
    else $error("hidden pixel carries a colour");

endmodule
